// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the line editor modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_RST(label, clk, rst_n, !(cond))

`endif

// File: design/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Types and character codes of the serial line editor
// ----------------------------------------------------------------------------
package sle_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_CONSUME = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_READY    = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_INVALID  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_ECHO_ENABLE   = 2'd0,
    CFG_TIMEOUT_MS    = 2'd1,
    CFG_LINE_CAPACITY = 2'd2
  } cfg_index_e;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  localparam logic out_kind_echo   = 1'b0;
  localparam logic out_kind_status = 1'b1;

  // everything one request produces: up to three echo bytes, then one status
  typedef struct packed {
    logic [2:0][7:0] echo;
    logic [1:0]      echo_cnt;
    logic [7:0]      fin_byte;
    status_e         fin_status;
    logic [6:0]      fin_len;
  } burst_t;

endpackage

// File: design/serial_line_editor_unit.sv
// ----------------------------------------------------------------------------
// serial_line_editor_unit
// Line editor for received serial bytes with backspace, echo and timeout
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  request  | in_valid_i / in_stall_o  | kind_i, byte_value_i, read_index_i
//  result   | out_valid_o / out_stall_i| out_kind_o, out_byte_o, status_o,
//           |                          | line_length_o, last_o
//  config   | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
//  a request is registered, then edited once the result register can take it;
//  its results go to the result register: its echo bytes, then one status
//  the result register plays out 1 to 4 results, one per cycle unless stalled,
//  so a request gives 1 result with echo off and 4 when it echoes three bytes
//  reset clears control and line state; the line store has no reset
//  a stalled result holds the edit stage, which in turn stalls requests
// ----------------------------------------------------------------------------
module serial_line_editor_unit #(
  parameter int LINE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  byte_value_i,
  input  logic [6:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic [6:0]  line_length_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);
  import sle_pkg::*;

`include "assert_macros.svh"

  localparam int CNT_W = (LINE_DEPTH > 2) ? $clog2(LINE_DEPTH) : 1;
  localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(LINE_DEPTH);

  // configuration
  logic        echo_en_q;
  logic [31:0] timeout_q;
  logic [7:0]  cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_en_q <= 1'b0;
      timeout_q <= '0;
      cap_q     <= 8'd128;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ECHO_ENABLE:   echo_en_q <= cfg_wdata_i[0];
        CFG_TIMEOUT_MS:    timeout_q <= cfg_wdata_i;
        CFG_LINE_CAPACITY: cap_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // request register
  logic        in_valid_q;
  kind_e       kind_q;
  logic [7:0]  byte_q;
  logic [6:0]  idx_q;
  logic [7:0]  rd_data_q;
  logic        seq_ready, proc_go, accept;

  assign proc_go    = in_valid_q && seq_ready;
  assign in_stall_o = in_valid_q && !proc_go;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (proc_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(kind_i);
      byte_q <= byte_value_i;
      idx_q  <= read_index_i;
    end
  end

  // line state
  logic [CNT_W-1:0] count_q, count_d;
  logic             started_q, started_d;
  logic             skip_lf_q, skip_lf_d;
  logic             waiting_q, waiting_d;
  logic             ovf_q, ovf_d;
  logic [31:0]      elapsed_q, elapsed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      started_q <= 1'b0;
      skip_lf_q <= 1'b0;
      waiting_q <= 1'b0;
      ovf_q     <= 1'b0;
      elapsed_q <= '0;
    end else if (proc_go) begin
      count_q   <= count_d;
      started_q <= started_d;
      skip_lf_q <= skip_lf_d;
      waiting_q <= waiting_d;
      ovf_q     <= ovf_d;
      elapsed_q <= elapsed_d;
    end
  end

  // line store, read at acceptance with forwarding of a same-cycle write
  logic [7:0]       line_mem [LINE_DEPTH];
  logic             wr_en;
  logic [CNT_W-1:0] wr_addr, rd_addr;
  logic [CMP_W-1:0] rd_idx_x;

  assign rd_idx_x = CMP_W'(read_index_i);
  assign rd_addr  = rd_idx_x[CNT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (proc_go && wr_en) begin
      line_mem[wr_addr] <= byte_q;
    end
    if (accept) begin
      if (proc_go && wr_en && (wr_addr == rd_addr)) begin
        rd_data_q <= byte_q;
      end else begin
        rd_data_q <= line_mem[rd_addr];
      end
    end
  end

  // edit logic
  logic             storage_ok, room, timed_out, idx_hit;
  logic [CMP_W-1:0] count_x, idx_x, cap_x, cap_eff;
  logic [31:0]      el_inc;
  burst_t           burst;
  status_e          cur_st;

  assign storage_ok = (cap_q >= 8'd2);
  assign count_x    = CMP_W'(count_q);
  assign idx_x      = CMP_W'(idx_q);
  assign cap_x      = CMP_W'(cap_q);
  assign cap_eff    = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
  assign room       = (count_x + CMP_W'(1)) < cap_eff;
  assign idx_hit    = storage_ok && (idx_x < count_x) && (idx_x < DEPTH_X);
  assign el_inc     = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
  assign wr_addr    = count_q;

  always_comb begin
    count_d   = count_q;
    started_d = started_q;
    skip_lf_d = skip_lf_q;
    waiting_d = waiting_q;
    ovf_d     = ovf_q;
    elapsed_d = elapsed_q;
    wr_en     = 1'b0;
    timed_out = 1'b0;
    burst     = '0;
    case (kind_q)
      KIND_BYTE: begin
        if (storage_ok && !waiting_q) begin
          started_d = 1'b1;
          if (!started_q) begin
            elapsed_d = '0;
          end
          skip_lf_d = 1'b0;
          if (skip_lf_q && (byte_q == CH_LF)) begin
            // lf of a cr lf pair: swallowed
          end else if ((byte_q == CH_CR) || (byte_q == CH_LF)) begin
            skip_lf_d = (byte_q == CH_CR);
            waiting_d = 1'b1;
            started_d = 1'b0;
            if (echo_en_q) begin
              burst.echo_cnt = 2'd2;
              burst.echo[0]  = CH_CR;
              burst.echo[1]  = CH_LF;
            end
          end else if ((byte_q == CH_BS) || (byte_q == CH_DEL)) begin
            if (count_q != '0) begin
              count_d = count_q - CNT_W'(1);
              if (echo_en_q) begin
                burst.echo_cnt = 2'd3;
                burst.echo[0]  = CH_BS;
                burst.echo[1]  = CH_SPACE;
                burst.echo[2]  = CH_BS;
              end
            end
          end else if (byte_q inside {[CH_SPACE:CH_TILDE], CH_TAB}) begin
            if (room) begin
              wr_en   = 1'b1;
              count_d = count_q + CNT_W'(1);
              if (echo_en_q) begin
                burst.echo_cnt = 2'd1;
                burst.echo[0]  = byte_q;
              end
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end
      KIND_TICK: begin
        if (storage_ok && started_q && !waiting_q) begin
          elapsed_d = el_inc;
          if ((timeout_q != '0) && (el_inc >= timeout_q)) begin
            timed_out = 1'b1;
            count_d   = '0;
            started_d = 1'b0;
            waiting_d = 1'b0;
            ovf_d     = 1'b0;
            elapsed_d = '0;
          end
        end
      end
      KIND_CONSUME: begin
        count_d   = '0;
        started_d = 1'b0;
        waiting_d = 1'b0;
        ovf_d     = 1'b0;
        elapsed_d = '0;
      end
      KIND_READ: begin
        if (idx_hit) begin
          burst.fin_byte = rd_data_q;
        end
      end
      default: ;
    endcase

    if (!storage_ok) begin
      cur_st = ST_INVALID;
    end else if (!waiting_d) begin
      cur_st = ST_PENDING;
    end else if (ovf_d) begin
      cur_st = ST_OVERFLOW;
    end else begin
      cur_st = ST_READY;
    end

    // timeout reports the length the line had before it was dropped
    if (timed_out) begin
      burst.fin_status = ST_TIMEOUT;
      burst.fin_len    = count_x[6:0];
    end else begin
      burst.fin_status = cur_st;
      burst.fin_len    = 7'(CMP_W'(count_d));
    end
  end

  sle_result_seq u_result_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (proc_go),
    .burst_i       (burst),
    .ready_o       (seq_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .line_length_o (line_length_o),
    .last_o        (last_o)
  );

  `ASSERT_NEVER(a_wait_not_started, clk_i, rst_ni, waiting_q && started_q)
  `ASSERT_RST(a_count_in_store, clk_i, rst_ni, count_x < DEPTH_X)
  `ASSERT_RST(a_accept_fills, clk_i, rst_ni, accept |=> in_valid_q)

endmodule

// File: design/sle_result_seq.sv
// ----------------------------------------------------------------------------
// sle_result_seq
// Result register that plays out the echo bytes and the status of a request
// ----------------------------------------------------------------------------
module sle_result_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  sle_pkg::burst_t burst_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           out_kind_o,
  output logic [7:0]     out_byte_o,
  output logic [2:0]     status_o,
  output logic [6:0]     line_length_o,
  output logic           last_o
);
  import sle_pkg::*;

`include "assert_macros.svh"

  burst_t     burst_q;
  logic [1:0] ptr_q, ptr_d;
  logic       valid_q, valid_d;
  logic       pop, at_final, last_pop;

  assign at_final = (ptr_q == burst_q.echo_cnt);
  assign pop      = valid_q && !out_stall_i;
  assign last_pop = pop && at_final;
  assign ready_o  = !valid_q || last_pop;

  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (load_i) begin
      valid_d = 1'b1;
      ptr_d   = '0;
    end else if (last_pop) begin
      valid_d = 1'b0;
    end else if (pop) begin
      ptr_d = ptr_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  assign out_valid_o = valid_q;

  always_comb begin
    if (!at_final) begin
      out_kind_o    = out_kind_echo;
      out_byte_o    = burst_q.echo[ptr_q];
      status_o      = ST_PENDING;
      line_length_o = '0;
      last_o        = 1'b0;
    end else begin
      out_kind_o    = out_kind_status;
      out_byte_o    = burst_q.fin_byte;
      status_o      = burst_q.fin_status;
      line_length_o = burst_q.fin_len;
      last_o        = 1'b1;
    end
  end

  `ASSERT_RST(a_ptr_in_burst, clk_i, rst_ni, valid_q |-> (ptr_q <= burst_q.echo_cnt))
  `ASSERT_RST(a_drain_empties, clk_i, rst_ni, (last_pop && !load_i) |=> !valid_q)
  `ASSERT_NEVER(a_load_busy, clk_i, rst_ni, load_i && !ready_o)

endmodule

// File: test/tb_serial_line_editor_unit.sv
// ----------------------------------------------------------------------------
// tb_serial_line_editor_unit
// Self-checking bench for the serial line editor: requests drawn from edited
// lines, reads, ticks and noise are played through the request channel while
// an in-bench line editor predicts every echo byte and status result
// ----------------------------------------------------------------------------
module tb_serial_line_editor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int DEPTH       = 128;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    kind_e      kind;
    logic [7:0] byte_value;
    logic [6:0] read_index;
  } request_t;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    status_e    status;
    logic [6:0] len;
    logic       last;
  } line_result_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i       = '0;
  logic [7:0]  byte_value_i = '0;
  logic [6:0]  read_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        out_kind_o;
  logic [7:0]  out_byte_o;
  logic [2:0]  status_o;
  logic [6:0]  line_length_o;
  logic        last_o;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_index_i  = '0;
  logic [31:0] cfg_wdata_i  = '0;

  serial_line_editor_unit #(
    .LINE_DEPTH(DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .byte_value_i (byte_value_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_kind_o   (out_kind_o),
    .out_byte_o   (out_byte_o),
    .status_o     (status_o),
    .line_length_o(line_length_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  request_t     request_q[$];
  line_result_t line_results_q[$];
  line_result_t want;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;
  int queued        = 0;
  int quiet         = 0;
  int errors        = 0;

  // predicted editor state and register copies
  logic [7:0]  ed_mem [DEPTH];
  int          ed_count    = 0;
  logic        ed_started  = 1'b0;
  logic        ed_skip_lf  = 1'b0;
  logic        ed_waiting  = 1'b0;
  logic        ed_overflow = 1'b0;
  logic [31:0] ed_elapsed  = '0;
  logic        echo_on       = 1'b0;
  logic [31:0] timeout_limit = '0;
  logic [7:0]  capacity      = 8'd128;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic status_e line_status();
    if (capacity < 2) return ST_INVALID;
    if (!ed_waiting) return ST_PENDING;
    return ed_overflow ? ST_OVERFLOW : ST_READY;
  endfunction

  function automatic void clear_line();
    ed_count    = 0;
    ed_started  = 1'b0;
    ed_waiting  = 1'b0;
    ed_overflow = 1'b0;
    ed_elapsed  = '0;
  endfunction

  function automatic void add_result(logic k, logic [7:0] b, status_e st, int len,
                                     logic last);
    line_result_t r;
    r.kind   = k;
    r.data   = b;
    r.status = st;
    r.len    = 7'(len);
    r.last   = last;
    line_results_q.push_back(r);
  endfunction

  // works out every result one request produces, in order
  function automatic void edit_line(request_t req);
    logic [7:0] c;
    logic [7:0] rd;
    int         ce;
    int         len;
    logic       ok;
    c  = req.byte_value;
    ok = capacity >= 2;
    ce = (capacity > DEPTH) ? DEPTH : int'(capacity);
    case (req.kind)
      KIND_BYTE: begin
        if (ok && !ed_waiting) begin
          if (!ed_started) begin
            ed_started = 1'b1;
            ed_elapsed = '0;
          end
          if (ed_skip_lf && c == CH_LF) begin
            ed_skip_lf = 1'b0;
          end else begin
            ed_skip_lf = 1'b0;
            if (c == CH_CR || c == CH_LF) begin
              ed_skip_lf = (c == CH_CR);
              if (echo_on) begin
                add_result(out_kind_echo, CH_CR, ST_PENDING, 0, 1'b0);
                add_result(out_kind_echo, CH_LF, ST_PENDING, 0, 1'b0);
              end
              ed_waiting = 1'b1;
              ed_started = 1'b0;
            end else if (c == CH_BS || c == CH_DEL) begin
              if (ed_count != 0) begin
                ed_count--;
                if (echo_on) begin
                  add_result(out_kind_echo, CH_BS, ST_PENDING, 0, 1'b0);
                  add_result(out_kind_echo, CH_SPACE, ST_PENDING, 0, 1'b0);
                  add_result(out_kind_echo, CH_BS, ST_PENDING, 0, 1'b0);
                end
              end
            end else if ((c >= CH_SPACE && c <= CH_TILDE) || c == CH_TAB) begin
              if (ed_count + 1 < ce) begin
                ed_mem[ed_count] = c;
                ed_count++;
                if (echo_on) add_result(out_kind_echo, c, ST_PENDING, 0, 1'b0);
              end else begin
                ed_overflow = 1'b1;
              end
            end
          end
        end
      end
      KIND_TICK: begin
        if (ok && ed_started && !ed_waiting) begin
          if (ed_elapsed != 32'hFFFF_FFFF) ed_elapsed++;
          if (timeout_limit != 0 && ed_elapsed >= timeout_limit) begin
            len = ed_count;
            clear_line();
            add_result(out_kind_status, 8'h00, ST_TIMEOUT, len, 1'b1);
            return;
          end
        end
      end
      KIND_CONSUME: clear_line();
      default: begin
        rd = 8'h00;
        if (ok && int'(req.read_index) < ed_count) rd = ed_mem[req.read_index];
        add_result(out_kind_status, rd, line_status(), ed_count, 1'b1);
        return;
      end
    endcase
    add_result(out_kind_status, 8'h00, line_status(), ed_count, 1'b1);
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) edit_line(request_q.pop_front());
      if (!(in_valid_i && in_stall_o)) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i   <= 1'b1;
          kind_i       <= request_q[0].kind;
          byte_value_i <= request_q[0].byte_value;
          read_index_i <= request_q[0].read_index;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor, receiver stall and watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (line_results_q.size() == 0) begin
          $error("unexpected result: out_kind %0d out_byte %0h status %0d len %0d",
                 out_kind_o, out_byte_o, status_o, line_length_o);
          errors++;
        end else begin
          want = line_results_q.pop_front();
          if (out_kind_o !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind_o);
            errors++;
          end
          if (out_byte_o !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_byte_o);
            errors++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            errors++;
          end
          if (line_length_o !== want.len) begin
            $error("line_length: expected %0d, got %0d", want.len, line_length_o);
            errors++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic queue_item(kind_e k, logic [7:0] b, logic [6:0] idx);
    request_t req;
    req.kind       = k;
    req.byte_value = b;
    req.read_index = idx;
    request_q.push_back(req);
    queued++;
  endtask

  task automatic drain();
    while (request_q.size() != 0 || in_valid_i || line_results_q.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ECHO_ENABLE: echo_on       = val[0];
      CFG_TIMEOUT_MS:  timeout_limit = val;
      default:         capacity      = val[7:0];
    endcase
  endtask

  task automatic configure(logic echo, logic [31:0] tmo, logic [7:0] cap, int send_pct,
                           int hold_pct);
    drain();
    write_reg(CFG_ECHO_ENABLE, {31'd0, echo});
    write_reg(CFG_TIMEOUT_MS, tmo);
    write_reg(CFG_LINE_CAPACITY, {24'd0, cap});
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    send_idle_pct =  send_pct;
    stall_pct     =  hold_pct;
  endtask

  // mostly whole lines (chars, erasures, ticks, end, reads, consume), some noise
  task automatic fill_lines(int target);
    int len;
    int ce;
    int run;
    int ri;
    queued = 0;
    ce  = (capacity > DEPTH) ? DEPTH : int'(capacity);
    run = (timeout_limit == 0 || timeout_limit > 40) ? 3 : int'(timeout_limit) + 1;
    while (queued < target) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_item(kind_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, 127)));
      end else begin
        // lines that run into the capacity only where they fit the budget
        if ($urandom_range(0, 15) == 0 && queued + ce + 2 <= target)
          len = $urandom_range(ce > 3 ? ce - 3 : 0, ce + 2);
        else len = $urandom_range(0, 10);
        for (int j = 0; j < len; j++) begin
          case ($urandom_range(0, 19))
            0: queue_item(KIND_BYTE, ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL, '0);
            1: repeat ($urandom_range(1, run)) queue_item(KIND_TICK, '0, '0);
            2: queue_item(KIND_BYTE, CH_TAB, '0);
            default: queue_item(KIND_BYTE, 8'($urandom_range(CH_SPACE, CH_TILDE)), '0);
          endcase
        end
        case ($urandom_range(0, 3))
          0: queue_item(KIND_BYTE, CH_CR, '0);
          1: queue_item(KIND_BYTE, CH_LF, '0);
          2: begin
            queue_item(KIND_BYTE, CH_CR, '0);
            queue_item(KIND_BYTE, CH_LF, '0);
          end
          default: repeat (run) queue_item(KIND_TICK, '0, '0);
        endcase
        repeat ($urandom_range(0, 3)) begin
          ri = $urandom_range(0, len + 1);
          if (ri > 127) ri = 127;
          queue_item(KIND_READ, '0, 7'(ri));
        end
        // dropped if the line waits
        if ($urandom_range(0, 3) == 0) queue_item(KIND_BYTE, 8'($urandom_range(0, 255)), '0);
        queue_item(KIND_CONSUME, '0, '0);
        if ($urandom_range(0, 3) == 0) queue_item(KIND_BYTE, CH_LF, '0);
      end
    end
  endtask

  task automatic random_traffic(int n, int holdoff);
    fill_lines(n / 2);
    hold_cycles = holdoff;
    // sender waits for every result before the second half
    drain();
    fill_lines(n - n / 2);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(1'b1, 32'd3, 8'd128, 0, 0);
    queue_item(KIND_BYTE, 8'h41, '0);
    queue_item(KIND_BYTE, CH_TAB, '0);
    queue_item(KIND_BYTE, CH_SPACE, '0);
    queue_item(KIND_BYTE, CH_TILDE, '0);
    queue_item(KIND_BYTE, 8'h1f, '0);
    queue_item(KIND_BYTE, 8'h80, '0);
    queue_item(KIND_BYTE, 8'hff, '0);
    queue_item(KIND_BYTE, CH_BS, '0);
    queue_item(KIND_BYTE, CH_DEL, '0);
    queue_item(KIND_READ, '0, 7'd0);
    queue_item(KIND_READ, '0, 7'd1);
    queue_item(KIND_READ, '0, 7'd127);
    queue_item(KIND_TICK, '0, '0);
    queue_item(KIND_BYTE, CH_CR, '0);
    queue_item(KIND_BYTE, 8'h42, '0);
    queue_item(KIND_TICK, '0, '0);
    queue_item(KIND_READ, '0, 7'd0);
    queue_item(KIND_CONSUME, '0, '0);
    // lf after consuming a cr line is still skipped but starts a line
    queue_item(KIND_BYTE, CH_LF, '0);
    repeat (3) queue_item(KIND_TICK, '0, '0);
    queue_item(KIND_TICK, '0, '0);
    queue_item(KIND_BYTE, CH_BS, '0);
    queue_item(KIND_BYTE, CH_LF, '0);
    queue_item(KIND_CONSUME, '0, '0);
    // full line at the widest count, the last two chars overflow
    for (int i = 0; i < 129; i++) queue_item(KIND_BYTE, 8'(8'h21 + i % 90), '0);
    queue_item(KIND_BYTE, CH_CR, '0);
    queue_item(KIND_READ, '0, 7'd126);
    queue_item(KIND_READ, '0, 7'd127);
    queue_item(KIND_CONSUME, '0, '0);
    random_traffic(30, 0);

    configure(1'b0, 32'd5, 8'd2, 62, 0);
    random_traffic(40, 0);
    configure(1'b1, 32'hFFFF_FFFF, 8'd255, 0, 62);
    random_traffic(40, 300);
    configure(1'b1, 32'd1, 8'd0, 33, 33);
    random_traffic(30, 0);
    configure(1'b1, 32'd12, 8'd6, 33, 33);
    random_traffic(40, 0);
    configure(1'b0, 32'd0, 8'd1, 0, 0);
    random_traffic(20, 0);
    configure(1'b1, 32'd30, 8'd40, 0, 62);
    random_traffic(40, 0);
    configure(1'b1, 32'd8, 8'd128, 62, 0);
    random_traffic(40, 0);

    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/sle_pkg.sv
design/sle_result_seq.sv
design/serial_line_editor_unit.sv
test/tb_serial_line_editor_unit.sv
